### hdl/serial_poll_link_controller_macros.svh
// assertion macros shared by the checker
`ifndef SERIAL_POLL_LINK_CONTROLLER_MACROS_SVH
`define SERIAL_POLL_LINK_CONTROLLER_MACROS_SVH

// implication checked outside reset
`define SPL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spl assertion failed");

// next-cycle implication, also checked during reset
`define SPL_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("spl assertion failed");

// next-cycle implication checked outside reset
`define SPL_ASSERT_NEXT_ON(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spl assertion failed");

`endif

### hdl/spl_pkg.sv
`default_nettype none
package spl_pkg;

  localparam int FRAME_BYTES     = 18;
  localparam int MAX_QUERIES_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int ADDR_W          = 5;
  localparam int MS_W            = 16;
  localparam int CNT_W           = 5;
  localparam int BUF_IDX_W       = $clog2(FRAME_BYTES);

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_S         = 8'h53;
  localparam logic [7:0] CH_Y         = 8'h59;
  localparam logic [7:0] CH_E         = 8'h45;
  localparam logic [7:0] CH_V         = 8'h56;
  localparam logic [7:0] CH_O         = 8'h4F;

  localparam logic [3:0] ID_LEN_SHORT = 4'd6;
  localparam logic [3:0] ID_LEN_LONG  = 4'd11;

  localparam logic [MS_W-1:0] MS_MAX = '1;

  localparam logic [15:0] RST_TX_THROTTLE = 16'd10;
  localparam logic [15:0] RST_RX_TIMEOUT  = 16'd100;
  localparam logic [15:0] RST_RSP_TIMEOUT = 16'd300;
  localparam logic [15:0] RST_BACKOFF     = 16'd1000;
  localparam logic [2:0]  RST_MAX_RETRIES = 3'd3;
  localparam logic [4:0]  RST_QUERY_COUNT = 5'd0;

  typedef enum logic [2:0] {
    REG_TX_THROTTLE,
    REG_RX_TIMEOUT,
    REG_RSP_TIMEOUT,
    REG_BACKOFF,
    REG_MAX_RETRIES,
    REG_QUERY_COUNT
  } reg_idx_e;

  typedef enum logic [2:0] {
    K_FRAME,
    K_INVALID,
    K_DROP,
    K_RESEND,
    K_QUEUED,
    K_QUERY,
    K_OFFLINE
  } kind_e;

  typedef enum logic [2:0] {
    CMD_DATA,
    CMD_CLEAR,
    CMD_CLOSE,
    CMD_TICK,
    CMD_POLL
  } cmd_code_e;

  typedef struct packed {
    cmd_code_e  code;
    logic [7:0] data;
    logic       queue_ready;
  } cmd_t;

  typedef struct packed {
    logic [15:0] tx_throttle_ms;
    logic [15:0] rx_timeout_ms;
    logic [15:0] response_timeout_ms;
    logic [15:0] offline_backoff_ms;
    logic [2:0]  max_retries;
    logic [4:0]  query_count;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
    logic [4:0] byte_index;
    logic [3:0] ident_len;
    logic [3:0] query_index;
    logic       offline;
    logic       flush_queue;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

### hdl/spl_if.sv
`default_nettype none
interface spl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;
  logic       queue_ready;

  modport source (output valid, output operation, output rx_byte, output queue_ready,
                  input ready);
  modport sink (input valid, input operation, input rx_byte, input queue_ready,
                output ready);
endinterface

interface spl_out_if;
  logic              valid;
  logic              ready;
  spl_pkg::kind_e    kind;
  logic [7:0]        byte_value;
  logic [4:0]        byte_index;
  logic [3:0]        ident_len;
  logic [3:0]        query_index;
  logic              offline;
  logic              flush_queue;
  logic              last;

  modport source (output valid, output kind, output byte_value, output byte_index,
                  output ident_len, output query_index, output offline,
                  output flush_queue, output last, input ready);
  modport sink (input valid, input kind, input byte_value, input byte_index,
                input ident_len, input query_index, input offline,
                input flush_queue, input last, output ready);
endinterface
`default_nettype wire

### hdl/spl_front.sv
`default_nettype none
module spl_front (
  spl_in_if.sink          req,
  input  wire logic       full,
  output spl_pkg::cmd_t   cmd,
  output logic            push
);

  logic known;

  assign req.ready = !full;

  always_comb begin
    known            = 1'b1;
    cmd.data         = req.rx_byte;
    cmd.queue_ready  = req.queue_ready;
    cmd.code         = spl_pkg::CMD_DATA;
    case (req.operation)
      spl_pkg::OP_BYTE: begin
        if (req.rx_byte == spl_pkg::CH_BACKSPACE) begin
          cmd.code = spl_pkg::CMD_CLEAR;
        end else if (req.rx_byte == spl_pkg::CH_RETURN) begin
          cmd.code = spl_pkg::CMD_CLOSE;
        end else begin
          cmd.code = spl_pkg::CMD_DATA;
        end
      end
      spl_pkg::OP_TICK: cmd.code = spl_pkg::CMD_TICK;
      spl_pkg::OP_POLL: cmd.code = spl_pkg::CMD_POLL;
      default: known = 1'b0;  // unused operation code is taken and dropped
    endcase
  end

  assign push = req.valid && !full && known;

endmodule
`default_nettype wire

### hdl/spl_queue.sv
`default_nettype none
module spl_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire spl_pkg::cmd_t  push_cmd,
  input  wire logic           pop,
  output spl_pkg::cmd_t       head,
  output logic                empty,
  output logic                full
);

  localparam int PTR_W = $clog2(spl_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(spl_pkg::QUEUE_DEPTH + 1);

  spl_pkg::cmd_t      slots [spl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(spl_pkg::QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/spl_back.sv
`default_nettype none
module spl_back #(
  parameter int MAX_QUERIES = spl_pkg::MAX_QUERIES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire spl_pkg::cfg_t  cfg,
  input  wire spl_pkg::cmd_t  cmd,
  input  wire logic           empty,
  output logic                pop,
  spl_out_if.source           rsp
);

  localparam int QW  = $clog2(MAX_QUERIES + 1);
  localparam int QCW = (QW > 5) ? QW : 5;
  localparam int BW  = spl_pkg::BUF_IDX_W;
  localparam int MW  = spl_pkg::MS_W;

  typedef enum logic [1:0] {S_IDLE, S_TICK_A, S_TICK_B, S_EMIT} state_t;

  typedef struct packed {
    logic drop;
    logic giveup;
    logic tx;
    logic frame;
    logic invalid;
    logic online;
  } pend_t;

  state_t              state;
  logic [7:0]          rx_buffer [spl_pkg::FRAME_BYTES];
  logic [spl_pkg::CNT_W-1:0] rx_count;
  logic [MW-1:0]       since_rx;
  logic [MW-1:0]       since_tx;
  logic                awaiting;
  logic                holding;
  logic [2:0]          retry;
  logic                offline_flag;
  logic [QW-1:0]       next_query;
  logic                tick_queue;
  pend_t               pend;
  logic [BW-1:0]       frame_idx;
  logic [3:0]          id_len;
  spl_pkg::kind_e      tx_kind;
  logic [3:0]          tx_q;
  logic                o_valid;
  spl_pkg::result_t    o_rec;
  logic                out_load;

  logic [QCW-1:0]      qc_ext;
  logic [QCW-1:0]      nq_ext;
  logic                syevo;

  // tick scheduler results
  logic                t_drop, t_giveup, t_tx;
  spl_pkg::kind_e      t_kind;
  logic                t_aw, t_hold, t_off, t_nq_inc;
  logic [2:0]          t_retry;

  // emit selection
  spl_pkg::result_t    e_rec;
  pend_t               e_pend;
  logic                e_frame;

  assign qc_ext = (QCW'(cfg.query_count) < QCW'(MAX_QUERIES)) ?
                  QCW'(cfg.query_count) : QCW'(MAX_QUERIES);
  assign nq_ext = QCW'(next_query);

  assign syevo = (rx_buffer[6] == spl_pkg::CH_S) && (rx_buffer[7] == spl_pkg::CH_Y) &&
                 (rx_buffer[8] == spl_pkg::CH_E) && (rx_buffer[9] == spl_pkg::CH_V) &&
                 (rx_buffer[10] == spl_pkg::CH_O);

  assign pop = (state == S_IDLE) && !empty;

  // output register takes a new result when empty or being drained
  assign out_load = (state == S_EMIT) && (!o_valid || rsp.ready);

  always_comb begin : tick_eval
    logic que;
    logic stop;
    que       = tick_queue;
    stop      = 1'b0;
    t_aw      = awaiting;
    t_hold    = holding;
    t_off     = offline_flag;
    t_retry   = retry;
    t_giveup  = 1'b0;
    t_tx      = 1'b0;
    t_nq_inc  = 1'b0;
    t_kind    = spl_pkg::K_RESEND;
    t_drop    = (rx_count != '0) && (since_rx > cfg.rx_timeout_ms);
    if (since_tx < cfg.tx_throttle_ms) begin
      stop = 1'b1;
    end
    if (!stop && awaiting) begin
      if (since_tx < cfg.response_timeout_ms) begin
        stop = 1'b1;
      end else begin
        t_aw = 1'b0;
        if (!offline_flag) begin
          if (retry < cfg.max_retries) begin
            t_retry = retry + 1'b1;
          end else begin
            t_retry  = '0;
            t_hold   = 1'b0;
            que      = 1'b0;
            t_off    = 1'b1;
            t_giveup = 1'b1;
          end
        end
      end
    end
    if (!stop && t_off && (since_tx < cfg.offline_backoff_ms)) begin
      stop = 1'b1;
    end
    if (!stop) begin
      if (t_hold) begin
        t_tx   = 1'b1;
        t_kind = spl_pkg::K_RESEND;
      end else if (que) begin
        t_tx   = 1'b1;
        t_kind = spl_pkg::K_QUEUED;
        t_hold = 1'b1;
      end else if (nq_ext < qc_ext) begin
        t_tx     = 1'b1;
        t_kind   = spl_pkg::K_QUERY;
        t_hold   = 1'b1;
        t_nq_inc = 1'b1;
      end
      if (t_tx) begin
        t_aw = 1'b1;
      end
    end
  end

  always_comb begin : emit_sel
    e_rec   = '0;
    e_pend  = pend;
    e_frame = 1'b0;
    if (pend.drop) begin
      e_rec.kind  = spl_pkg::K_DROP;
      e_pend.drop = 1'b0;
    end else if (pend.giveup) begin
      e_rec.kind        = spl_pkg::K_OFFLINE;
      e_rec.offline     = 1'b1;
      e_rec.flush_queue = 1'b1;
      e_pend.giveup     = 1'b0;
    end else if (pend.tx) begin
      e_rec.kind        = tx_kind;
      e_rec.query_index = (tx_kind == spl_pkg::K_QUERY) ? tx_q : 4'd0;
      e_pend.tx         = 1'b0;
    end else if (pend.frame) begin
      e_frame          = 1'b1;
      e_rec.kind       = spl_pkg::K_FRAME;
      e_rec.byte_value = rx_buffer[frame_idx];
      e_rec.byte_index = 5'(frame_idx);
      e_rec.ident_len  = id_len;
      if (frame_idx == BW'(spl_pkg::FRAME_BYTES - 1)) begin
        e_pend.frame = 1'b0;
      end
    end else if (pend.invalid) begin
      e_rec.kind     = spl_pkg::K_INVALID;
      e_pend.invalid = 1'b0;
    end else if (pend.online) begin
      e_rec.kind    = spl_pkg::K_OFFLINE;
      e_pend.online = 1'b0;
    end
    e_rec.last = (e_pend == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      o_valid      <= 1'b0;
      rx_count     <= '0;
      since_rx     <= '0;
      since_tx     <= '0;
      awaiting     <= 1'b0;
      holding      <= 1'b0;
      retry        <= '0;
      offline_flag <= 1'b0;
      next_query   <= '0;
      pend         <= '0;
    end else begin
      if (out_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            case (cmd.code)
              spl_pkg::CMD_DATA: begin
                if (rx_count < spl_pkg::CNT_W'(spl_pkg::FRAME_BYTES)) begin
                  rx_buffer[rx_count[BW-1:0]] <= cmd.data;
                end
                // count stops one past a full frame so overlong frames are flagged
                if (rx_count < spl_pkg::CNT_W'(spl_pkg::FRAME_BYTES + 1)) begin
                  rx_count <= rx_count + 1'b1;
                end
                since_rx <= '0;
              end
              spl_pkg::CMD_CLEAR: rx_count <= '0;
              spl_pkg::CMD_CLOSE: begin
                if (rx_count == spl_pkg::CNT_W'(spl_pkg::FRAME_BYTES)) begin
                  pend.frame <= 1'b1;
                  frame_idx  <= '0;
                  id_len     <= syevo ? spl_pkg::ID_LEN_LONG : spl_pkg::ID_LEN_SHORT;
                end else begin
                  pend.invalid <= 1'b1;
                end
                pend.online  <= offline_flag;
                offline_flag <= 1'b0;
                rx_count     <= '0;
                holding      <= 1'b0;
                awaiting     <= 1'b0;
                state        <= S_EMIT;
              end
              spl_pkg::CMD_TICK: begin
                tick_queue <= cmd.queue_ready;
                state      <= S_TICK_A;
              end
              spl_pkg::CMD_POLL: begin
                if (!offline_flag && !(nq_ext < qc_ext)) begin
                  next_query <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_TICK_A: begin
          since_rx <= (since_rx == spl_pkg::MS_MAX) ? since_rx : since_rx + 1'b1;
          since_tx <= (since_tx == spl_pkg::MS_MAX) ? since_tx : since_tx + 1'b1;
          state    <= S_TICK_B;
        end
        S_TICK_B: begin
          if (t_drop) begin
            rx_count <= '0;
          end
          awaiting     <= t_aw;
          holding      <= t_hold;
          retry        <= t_retry;
          offline_flag <= t_off;
          if (t_tx) begin
            since_tx <= '0;
          end
          if (t_nq_inc) begin
            next_query <= next_query + 1'b1;
          end
          tx_kind     <= t_kind;
          tx_q        <= 4'(next_query);
          pend.drop   <= t_drop;
          pend.giveup <= t_giveup;
          pend.tx     <= t_tx;
          state       <= (t_drop || t_giveup || t_tx) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_load) begin
            o_rec   <= e_rec;
            pend    <= e_pend;
            if (e_frame) begin
              frame_idx <= frame_idx + 1'b1;
            end
            if (e_rec.last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.kind        = o_rec.kind;
  assign rsp.byte_value  = o_rec.byte_value;
  assign rsp.byte_index  = o_rec.byte_index;
  assign rsp.ident_len   = o_rec.ident_len;
  assign rsp.query_index = o_rec.query_index;
  assign rsp.offline     = o_rec.offline;
  assign rsp.flush_queue = o_rec.flush_queue;
  assign rsp.last        = o_rec.last;

endmodule
`default_nettype wire

### hdl/serial_poll_link_controller.sv
// serial poll link controller
// req channel: one item per received byte, millisecond tick or poll-cycle start,
// accepted when valid and ready are high at a rising edge of clk.
// rsp channel: result items, the final result for an input item marked by last.
// an accepted item of a known operation passes a four-entry command queue, then
// the back end: data, clear and poll items are handled in the idle state, a tick
// passes tick_a and tick_b and emits up to 3 results, a closing byte up to 19.
// a first result passes the queue, the idle and emit states and the output register.
// data bytes sustain one item per cycle while the back end is idle; ticks and
// closing bytes hold the single back-end sequencer, which works one command at a time.
// the output register holds a result until rsp.ready; the back end then waits,
// the queue fills, and req.ready drops once four items are pending.
// configuration through the apb port, register i at byte address 4*i, is to be
// written by the user only while the block is idle, which the block does not
// enforce; pready is always high. synchronous reset empties the queue, drops any
// result in flight, clears counters and link state and restores register defaults.
`default_nettype none
module serial_poll_link_controller #(
  parameter int MAX_QUERIES = spl_pkg::MAX_QUERIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  spl_in_if.sink                           req,
  spl_out_if.source                        rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spl_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  spl_pkg::cfg_t cfg;
  spl_pkg::cmd_t push_cmd;
  spl_pkg::cmd_t head;
  logic          push;
  logic          pop;
  logic          empty;
  logic          full;
  spl_pkg::reg_idx_e reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = spl_pkg::reg_idx_e'(paddr[spl_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tx_throttle_ms      <= spl_pkg::RST_TX_THROTTLE;
      cfg.rx_timeout_ms       <= spl_pkg::RST_RX_TIMEOUT;
      cfg.response_timeout_ms <= spl_pkg::RST_RSP_TIMEOUT;
      cfg.offline_backoff_ms  <= spl_pkg::RST_BACKOFF;
      cfg.max_retries         <= spl_pkg::RST_MAX_RETRIES;
      cfg.query_count         <= spl_pkg::RST_QUERY_COUNT;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        spl_pkg::REG_TX_THROTTLE: cfg.tx_throttle_ms      <= pwdata[15:0];
        spl_pkg::REG_RX_TIMEOUT:  cfg.rx_timeout_ms       <= pwdata[15:0];
        spl_pkg::REG_RSP_TIMEOUT: cfg.response_timeout_ms <= pwdata[15:0];
        spl_pkg::REG_BACKOFF:     cfg.offline_backoff_ms  <= pwdata[15:0];
        spl_pkg::REG_MAX_RETRIES: cfg.max_retries         <= pwdata[2:0];
        spl_pkg::REG_QUERY_COUNT: cfg.query_count         <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      spl_pkg::REG_TX_THROTTLE: prdata = 32'(cfg.tx_throttle_ms);
      spl_pkg::REG_RX_TIMEOUT:  prdata = 32'(cfg.rx_timeout_ms);
      spl_pkg::REG_RSP_TIMEOUT: prdata = 32'(cfg.response_timeout_ms);
      spl_pkg::REG_BACKOFF:     prdata = 32'(cfg.offline_backoff_ms);
      spl_pkg::REG_MAX_RETRIES: prdata = 32'(cfg.max_retries);
      spl_pkg::REG_QUERY_COUNT: prdata = 32'(cfg.query_count);
      default:                  prdata = '0;
    endcase
  end

  spl_front u_front (
    .req  (req),
    .full (full),
    .cmd  (push_cmd),
    .push (push)
  );

  spl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  spl_back #(
    .MAX_QUERIES (MAX_QUERIES)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cmd   (head),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule
`default_nettype wire

### hdl/spl_checker.sv
`default_nettype none
`include "serial_poll_link_controller_macros.svh"
module spl_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire spl_pkg::kind_e kind,
  input wire logic [7:0]     byte_value,
  input wire logic [4:0]     byte_index,
  input wire logic [3:0]     ident_len,
  input wire logic           offline,
  input wire logic           flush_queue,
  input wire logic           last
);

  // a stalled result keeps its payload
  `SPL_ASSERT_NEXT_ON(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(kind) && $stable(byte_value) && $stable(byte_index) && $stable(last))

  // nothing left over from before reset
  `SPL_ASSERT_NEXT(a_reset, clk, rst, !rsp_valid)

  // frame bytes carry a legal id length, and only the closing position ends the item
  `SPL_ASSERT_IMP(a_frame_len, clk, rst, rsp_valid && kind == spl_pkg::K_FRAME, (ident_len == spl_pkg::ID_LEN_SHORT || ident_len == spl_pkg::ID_LEN_LONG) && byte_index < 5'(spl_pkg::FRAME_BYTES))
  `SPL_ASSERT_IMP(a_frame_last, clk, rst, rsp_valid && kind == spl_pkg::K_FRAME && byte_index != 5'(spl_pkg::FRAME_BYTES - 1), !last)

  // queue flush only comes with the link going offline
  `SPL_ASSERT_IMP(a_flush, clk, rst, rsp_valid && flush_queue, kind == spl_pkg::K_OFFLINE && offline)

endmodule

bind serial_poll_link_controller spl_checker u_spl_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .kind        (rsp.kind),
  .byte_value  (rsp.byte_value),
  .byte_index  (rsp.byte_index),
  .ident_len   (rsp.ident_len),
  .offline     (rsp.offline),
  .flush_queue (rsp.flush_queue),
  .last        (rsp.last)
);
`default_nettype wire
